// ===== hw/rtl/irfs_pkg.sv =====
// Shared types, constants and index tables for the incremental rotation pipeline.
package irfs_pkg;

    localparam int ISQRT_STG = 32;
    localparam int N_TERMS   = 12;
    localparam int SUBSTEPS  = 5;
    localparam int CORE_STG  = N_TERMS * SUBSTEPS;
    localparam int DIV_STG   = 31;
    localparam int NSTG      = 1 + ISQRT_STG + 1 + CORE_STG + 1 + 4;

    localparam logic [31:0] SMALL_NORM_Q28 = 32'd269;
    localparam logic [31:0] PI_Q28         = 32'd843314857;
    localparam logic [30:0] ONE_Q30        = 31'h4000_0000;

    localparam logic signed [63:0] RND_Q30      = 64'sd536870912;
    localparam logic signed [63:0] RND_Q30_DIAG = 64'sd536870912 - 64'sd1152921504606846976;
    localparam logic signed [63:0] RND_ROT_DIAG = 64'sd536870912 + 64'sd1152921504606846976;

    // Unique products u_a * u_b: the three squares first, then the cross terms.
    localparam int UU_A [6] = '{0, 1, 2, 0, 0, 1};
    localparam int UU_B [6] = '{0, 1, 2, 1, 2, 2};

    // How each matrix entry, row by row, draws on the sine and cosine products.
    localparam logic [8:0] SU_USE = 9'b011101110;
    localparam logic [8:0] SU_NEG = 9'b001100010;
    localparam logic [8:0] DIAG   = 9'b100010001;
    localparam int SU_IDX [9] = '{0, 2, 1, 2, 0, 0, 1, 0, 0};
    localparam int CU_IDX [9] = '{0, 3, 4, 3, 1, 5, 4, 5, 2};

    typedef struct packed {
        logic [2:0][31:0] w;
        logic [2:0][63:0] sq;
    } t_sqr_st;

    typedef struct packed {
        logic [2:0][31:0] w;
        logic [63:0]      rad;
        logic [33:0]      rem;
        logic [31:0]      root;
    } t_sqrt_st;

    typedef struct packed {
        logic [2:0]       neg;
        logic             tiny;
        logic             ovf;
        logic [31:0]      n;
        logic [2:0][31:0] rem;
        logic [2:0][30:0] lo;
        logic [2:0][30:0] q;
        logic [30:0]      h;
        logic [1:0][30:0] tm;
        logic [1:0][33:0] sm;
        logic [1:0][31:0] y1;
        logic [1:0][32:0] y2;
        logic [1:0][32:0] q0;
        logic [1:0][33:0] qd;
    } t_core_st;

    typedef struct packed {
        logic             tiny;
        logic             ovf;
        logic [2:0][31:0] u;
        logic [61:0]      psc;
        logic [61:0]      pss;
        logic [5:0][61:0] puu;
        logic [5:0]       nuu;
    } t_p1_st;

    typedef struct packed {
        logic             tiny;
        logic             ovf;
        logic [2:0][31:0] u;
        logic [32:0]      s;
        logic [32:0]      c;
        logic [5:0][32:0] e;
    } t_p2_st;

    typedef struct packed {
        logic             tiny;
        logic             ovf;
        logic [2:0][63:0] su;
        logic [5:0][63:0] cu;
    } t_p3_st;

    typedef struct packed {
        logic [8:0][31:0] rot;
        logic             ovf;
    } t_res_st;

endpackage

// ===== hw/rtl/incremental_rotation_from_spin.sv =====
// Incremental rotation matrix from a spin vector, as a fully pipelined datapath.
//
//  port group   dir  tdata fields (low bit up)                    tuser
//  i_s_*        in   spin_x, spin_y, spin_z (Q3.28)               -
//  o_m_*        out  rot_11 .. rot_33 row by row (Q1.30)          angle_overflow
//
// A new beat is taken every cycle while the skid register is empty.
// The depth is set by the 32-step square root and the 60-stage sine/cosine series,
// which runs alongside the 31-step unit-vector divider.
// Reset clears only the valid bits and the output/skid flags.
// A stalled output fills a one-beat skid register; only then does the whole pipeline hold.
module incremental_rotation_from_spin import irfs_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [95:0]  i_s_tdata,   // spin_x, spin_y, spin_z
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [287:0] o_m_tdata,   // rot_11, rot_12, rot_13, rot_21, ..., rot_33
    output logic         o_m_tuser    // angle_overflow
);

    logic            pipe_en;
    logic            in_beat;
    logic [NSTG-1:0] r_vld;

    t_sqr_st  r_sq,  n_sq;
    t_sqrt_st r_rt   [ISQRT_STG+1];
    t_sqrt_st n_rt   [ISQRT_STG+1];
    t_core_st r_core [CORE_STG+1];
    t_core_st n_core [CORE_STG+1];
    t_p1_st   r_p1,  n_p1;
    t_p2_st   r_p2,  n_p2;
    t_p3_st   r_p3,  n_p3;
    t_res_st  r_res, n_res;
    t_res_st  r_od,  r_sd;
    logic     r_ov,  r_sv;

    assign pipe_en    = ~r_sv;
    assign o_s_tready = pipe_en;
    assign in_beat    = i_s_tvalid & pipe_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (pipe_en) begin
            r_vld <= {r_vld[NSTG-2:0], in_beat};
        end
    end

    // Absolute values and squares.
    always_comb begin
        logic [31:0] a;
        n_sq.w = i_s_tdata;
        for (int i = 0; i < 3; i++) begin
            a = i_s_tdata[32*i+31] ? 32'(-i_s_tdata[32*i +: 32]) : i_s_tdata[32*i +: 32];
            n_sq.sq[i] = 64'(a) * 64'(a);
        end
    end

    always_comb begin
        n_rt[0].w    = r_sq.w;
        n_rt[0].rad  = r_sq.sq[0] + r_sq.sq[1] + r_sq.sq[2];
        n_rt[0].rem  = '0;
        n_rt[0].root = '0;
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_sq    <= n_sq;
            r_rt[0] <= n_rt[0];
        end
    end

    // Integer square root, two radicand bits per stage.
    for (genvar k = 1; k <= ISQRT_STG; k++) begin : g_sqrt
        always_comb begin
            logic [35:0] rem2;
            logic [35:0] trial;
            rem2  = {r_rt[k-1].rem, r_rt[k-1].rad[63:62]};
            trial = {2'b00, r_rt[k-1].root, 2'b01};
            n_rt[k].w   = r_rt[k-1].w;
            n_rt[k].rad = {r_rt[k-1].rad[61:0], 2'b00};
            if (rem2 >= trial) begin
                n_rt[k].rem  = 34'(rem2 - trial);
                n_rt[k].root = {r_rt[k-1].root[30:0], 1'b1};
            end else begin
                n_rt[k].rem  = rem2[33:0];
                n_rt[k].root = {r_rt[k-1].root[30:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (pipe_en) begin
                r_rt[k] <= n_rt[k];
            end
        end
    end

    // Set up the dividers and the two series from the norm.
    always_comb begin
        logic [31:0] nrm;
        logic [31:0] a;
        logic [61:0] num;
        nrm = r_rt[ISQRT_STG].root;
        n_core[0] = '0;
        n_core[0].n    = nrm;
        n_core[0].tiny = nrm < SMALL_NORM_Q28;
        n_core[0].ovf  = nrm >= PI_Q28;
        for (int i = 0; i < 3; i++) begin
            a = r_rt[ISQRT_STG].w[i][31] ? 32'(-r_rt[ISQRT_STG].w[i]) : r_rt[ISQRT_STG].w[i];
            num = {a, 30'd0} + 62'(nrm >> 1);
            n_core[0].neg[i] = r_rt[ISQRT_STG].w[i][31];
            n_core[0].rem[i] = {1'b0, num[61:31]};
            n_core[0].lo[i]  = num[30:0];
        end
        n_core[0].h     = {nrm[29:0], 1'b0};
        n_core[0].tm[0] = {nrm[29:0], 1'b0};
        n_core[0].sm[0] = 34'({nrm[29:0], 1'b0});
        n_core[0].tm[1] = ONE_Q30;
        n_core[0].sm[1] = 34'(ONE_Q30);
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_core[0] <= n_core[0];
        end
    end

    // Divider bits and series terms; each term takes five stages.
    for (genvar j = 1; j <= CORE_STG; j++) begin : g_core
        localparam int  SUB    = (j - 1) % SUBSTEPS;
        localparam int  K      = (j - 1) / SUBSTEPS + 1;
        localparam bit  DIV_ON = (j <= DIV_STG);
        localparam bit  MINUS  = (K % 2) == 1;
        localparam int  D_S    = (2 * K) * (2 * K + 1);
        localparam int  D_C    = (2 * K - 1) * (2 * K);
        localparam logic [32:0] R_S = 33'((64'd1 << 33) / 64'(D_S));
        localparam logic [32:0] R_C = 33'((64'd1 << 33) / 64'(D_C));

        always_comb begin
            logic [32:0] rem2;
            logic        ge;
            logic [61:0] p1;
            logic [63:0] p2;
            logic [65:0] p3;
            logic [43:0] p4;
            logic [33:0] rr;
            logic [32:0] qq;
            logic [32:0] rcp;
            logic [9:0]  dv;
            n_core[j] = r_core[j-1];
            if (DIV_ON) begin
                for (int i = 0; i < 3; i++) begin
                    rem2 = {r_core[j-1].rem[i], r_core[j-1].lo[i][30]};
                    ge   = rem2 >= {1'b0, r_core[j-1].n};
                    n_core[j].rem[i] = ge ? 32'(rem2 - {1'b0, r_core[j-1].n}) : rem2[31:0];
                    n_core[j].q[i]   = {r_core[j-1].q[i][29:0], ge};
                    n_core[j].lo[i]  = {r_core[j-1].lo[i][29:0], 1'b0};
                end
            end
            for (int s = 0; s < 2; s++) begin
                rcp = (s == 0) ? R_S : R_C;
                dv  = (s == 0) ? 10'(D_S) : 10'(D_C);
                case (SUB)
                    0: begin
                        p1 = 62'(r_core[j-1].tm[s]) * 62'(r_core[j-1].h);
                        n_core[j].y1[s] = p1[61:30];
                    end
                    1: begin
                        p2 = 64'(r_core[j-1].y1[s]) * 64'(r_core[j-1].h);
                        n_core[j].y2[s] = p2[62:30];
                    end
                    2: begin
                        // Reciprocal estimate: low by at most one.
                        p3 = 66'(r_core[j-1].y2[s]) * 66'(rcp);
                        n_core[j].q0[s] = p3[65:33];
                    end
                    3: begin
                        p4 = 44'(r_core[j-1].q0[s]) * 44'(dv);
                        n_core[j].qd[s] = p4[33:0];
                    end
                    4: begin
                        rr = 34'(r_core[j-1].y2[s]) - r_core[j-1].qd[s];
                        qq = r_core[j-1].q0[s] + 33'(rr >= 34'(dv));
                        n_core[j].tm[s] = qq[30:0];
                        n_core[j].sm[s] = MINUS ? r_core[j-1].sm[s] - 34'(qq)
                                                : r_core[j-1].sm[s] + 34'(qq);
                    end
                    default: begin
                    end
                endcase
            end
        end

        always_ff @(posedge i_clk) begin
            if (pipe_en) begin
                r_core[j] <= n_core[j];
            end
        end
    end

    // Clamp the series, form sin*cos, sin^2 and the unit-vector products.
    always_comb begin
        logic signed [33:0] sv;
        logic [1:0][30:0]   cl;
        for (int s = 0; s < 2; s++) begin
            sv = $signed(r_core[CORE_STG].sm[s]);
            if (sv < 34'sd0) begin
                cl[s] = '0;
            end else if (sv > 34'sd1073741824) begin
                cl[s] = ONE_Q30;
            end else begin
                cl[s] = sv[30:0];
            end
        end
        n_p1.tiny = r_core[CORE_STG].tiny;
        n_p1.ovf  = r_core[CORE_STG].ovf;
        n_p1.psc  = 62'(cl[0]) * 62'(cl[1]);
        n_p1.pss  = 62'(cl[0]) * 62'(cl[0]);
        for (int i = 0; i < 3; i++) begin
            n_p1.u[i] = r_core[CORE_STG].neg[i] ? 32'(-{1'b0, r_core[CORE_STG].q[i]})
                                                : {1'b0, r_core[CORE_STG].q[i]};
        end
        for (int m = 0; m < 6; m++) begin
            n_p1.puu[m] = 62'(r_core[CORE_STG].q[UU_A[m]]) * 62'(r_core[CORE_STG].q[UU_B[m]]);
            n_p1.nuu[m] = r_core[CORE_STG].neg[UU_A[m]] ^ r_core[CORE_STG].neg[UU_B[m]];
        end
    end

    // Round the terms; at a half turn and beyond the sine term vanishes and C is two.
    always_comb begin
        logic [61:0]        t;
        logic signed [63:0] v;
        n_p2.tiny = r_p1.tiny;
        n_p2.ovf  = r_p1.ovf;
        n_p2.u    = r_p1.u;
        t = r_p1.psc + 62'd268435456;
        n_p2.s = r_p1.ovf ? 33'd0 : t[61:29];
        t = r_p1.pss + 62'd268435456;
        n_p2.c = r_p1.ovf ? 33'h0_8000_0000 : t[61:29];
        for (int m = 0; m < 6; m++) begin
            v = r_p1.nuu[m] ? -$signed({2'b00, r_p1.puu[m]}) : $signed({2'b00, r_p1.puu[m]});
            v = v + ((m < 3) ? RND_Q30_DIAG : RND_Q30);
            n_p2.e[m] = v[62:30];
        end
    end

    always_comb begin
        logic signed [65:0] pr;
        n_p3.tiny = r_p2.tiny;
        n_p3.ovf  = r_p2.ovf;
        for (int i = 0; i < 3; i++) begin
            pr = $signed(r_p2.s) * $signed(r_p2.u[i]);
            n_p3.su[i] = pr[63:0];
        end
        for (int m = 0; m < 6; m++) begin
            pr = $signed(r_p2.c) * $signed(r_p2.e[m]);
            n_p3.cu[m] = pr[63:0];
        end
    end

    always_comb begin
        logic signed [63:0] acc;
        logic signed [63:0] sterm;
        logic signed [33:0] rnd;
        n_res.ovf = r_p3.ovf & ~r_p3.tiny;
        for (int k = 0; k < 9; k++) begin
            sterm = $signed(r_p3.su[SU_IDX[k]]);
            if (!SU_USE[k]) begin
                sterm = '0;
            end else if (SU_NEG[k]) begin
                sterm = -sterm;
            end
            acc = $signed(r_p3.cu[CU_IDX[k]]) + sterm + (DIAG[k] ? RND_ROT_DIAG : RND_Q30);
            rnd = acc[63:30];
            if (r_p3.tiny) begin
                n_res.rot[k] = DIAG[k] ? 32'h4000_0000 : 32'd0;
            end else if (rnd > 34'sd2147483647) begin
                n_res.rot[k] = 32'h7fff_ffff;
            end else if (rnd < -34'sd2147483648) begin
                n_res.rot[k] = 32'h8000_0000;
            end else begin
                n_res.rot[k] = rnd[31:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_p1  <= n_p1;
            r_p2  <= n_p2;
            r_p3  <= n_p3;
            r_res <= n_res;
        end
    end

    // Output register with a one-beat skid behind it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else if (!r_ov || i_m_tready) begin
            if (r_sv) begin
                r_ov <= 1'b1;
                r_sv <= 1'b0;
            end else begin
                r_ov <= r_vld[NSTG-1];
            end
        end else if (r_vld[NSTG-1] && pipe_en) begin
            r_sv <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_ov || i_m_tready) begin
            r_od <= r_sv ? r_sd : r_res;
        end
        if (r_ov && !i_m_tready && pipe_en) begin
            r_sd <= r_res;
        end
    end

    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = r_od.rot;
    assign o_m_tuser  = r_od.ovf;

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sv |-> r_ov)
        else $error("skid holds a beat while the output register is empty");

    a_stall_freezes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !pipe_en |=> $stable(r_vld))
        else $error("pipeline valid bits moved during a stall");

    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_sv) |-> $past(r_ov && !i_m_tready))
        else $error("skid filled while the output was free");

endmodule
